### sv/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg
// Shared constants, codes and control types of the compacting list store.
// ----------------------------------------------------------------------------
package cls_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int POS_W  = 6;
    localparam int IDX_W  = 6;
    localparam int LCNT_W = 7;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_UPDATE  = 2'd1,
        CMD_DELETE  = 2'd2,
        CMD_DISPLAY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADIDX = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_STAT,
        S_DISP_RD,
        S_DISP
    } t_state;

    typedef struct packed {
        logic    load_in;
        logic    wr_append;
        logic    wr_update;
        logic    set_status;
        t_status status;
        logic    j_from_pos;
        logic    j_clear;
        logic    shift_step;
        logic    shift_end;
        logic    emit_status;
        logic    emit_entry;
    } t_dp_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic pos_ok;
        logic full;
        logic empty;
        logic shift_done;
        logic disp_last;
        logic out_free;
    } t_dp_stat;

endpackage

### sv/cls_in_if.sv
// ----------------------------------------------------------------------------
// cls_in_if
// Command channel: one transfer carries one list command.
// ----------------------------------------------------------------------------
interface cls_in_if;
    import cls_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] data_word;

    modport source (output valid, output cmd, output position, output data_word,
                    input ready);
    modport sink   (input valid, input cmd, input position, input data_word,
                    output ready);
endinterface

### sv/cls_out_if.sv
// ----------------------------------------------------------------------------
// cls_out_if
// Result channel: one transfer carries one result of a list command.
// ----------------------------------------------------------------------------
interface cls_out_if;
    import cls_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [WORD_W-1:0] entry_value;
    logic [IDX_W-1:0]         entry_index;
    logic [LCNT_W-1:0]        live_count;
    logic                     last;

    modport source (output valid, output status, output entry_value,
                    output entry_index, output live_count, output last,
                    input ready);
    modport sink   (input valid, input status, input entry_value,
                    input entry_index, input live_count, input last,
                    output ready);
endinterface

### sv/cls_ram.sv
// ----------------------------------------------------------------------------
// cls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/cls_ctrl.sv
// ----------------------------------------------------------------------------
// cls_ctrl
// Command sequencer: decodes each command and steps the datapath through it.
// ----------------------------------------------------------------------------
module cls_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cls_pkg::t_dp_stat i_stat,
    output cls_pkg::t_dp_ctrl o_ctrl
);
    import cls_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.cmd)
                    CMD_DELETE:  n_state = i_stat.pos_ok ? S_SHIFT : S_STAT;
                    CMD_DISPLAY: n_state = i_stat.empty ? S_STAT : S_DISP_RD;
                    default:     n_state = S_STAT;
                endcase
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    n_state = S_STAT;
                end
            end
            S_STAT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DISP_RD: n_state = S_DISP;
            S_DISP: begin
                if (i_stat.out_free && i_stat.disp_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_ctrl.load_in = i_in_valid;
            end
            S_EXEC: begin
                o_ctrl.set_status = 1'b1;
                o_ctrl.status     = ST_OK;
                case (i_stat.cmd)
                    CMD_INSERT: begin
                        if (i_stat.full) begin
                            o_ctrl.status = ST_FULL;
                        end else begin
                            o_ctrl.wr_append = 1'b1;
                        end
                    end
                    CMD_UPDATE: begin
                        if (i_stat.pos_ok) begin
                            o_ctrl.wr_update = 1'b1;
                        end else begin
                            o_ctrl.status = ST_BADIDX;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.pos_ok) begin
                            o_ctrl.j_from_pos = 1'b1;
                        end else begin
                            o_ctrl.status = ST_BADIDX;
                        end
                    end
                    default: begin
                        if (i_stat.empty) begin
                            o_ctrl.status = ST_EMPTY;
                        end else begin
                            o_ctrl.j_clear = 1'b1;
                        end
                    end
                endcase
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    o_ctrl.shift_end  = 1'b1;
                    o_ctrl.set_status = 1'b1;
                    o_ctrl.status     = ST_OK;
                end else begin
                    o_ctrl.shift_step = 1'b1;
                end
            end
            S_STAT: o_ctrl.emit_status = i_stat.out_free;
            S_DISP: o_ctrl.emit_entry  = i_stat.out_free;
            default: o_ctrl = '0;
        endcase
    end
endmodule

### sv/cls_dp.sv
// ----------------------------------------------------------------------------
// cls_dp
// Datapath: command registers, entry count, entry RAM, shift pointer and the
// result register.
// ----------------------------------------------------------------------------
module cls_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [1:0]                        i_cmd,
    input  logic [cls_pkg::POS_W-1:0]         i_position,
    input  logic signed [cls_pkg::WORD_W-1:0] i_data_word,
    input  cls_pkg::t_dp_ctrl                 i_ctrl,
    output cls_pkg::t_dp_stat                 o_stat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic signed [cls_pkg::WORD_W-1:0] o_entry_value,
    output logic [cls_pkg::IDX_W-1:0]         o_entry_index,
    output logic [cls_pkg::LCNT_W-1:0]        o_live_count,
    output logic                              o_last
);
    import cls_pkg::*;

    t_cmd              r_cmd;
    logic [POS_W-1:0]  r_pos;
    logic [WORD_W-1:0] r_word;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_j;
    logic              r_pend;
    t_status           r_stat_code;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [WORD_W-1:0] r_out_value;
    logic [IDX_W-1:0]  r_out_index;
    logic [LCNT_W-1:0] r_out_count;
    logic              r_out_last;

    logic [CNT_W-1:0]  j_inc;
    logic [CNT_W-1:0]  j_dec;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;

    assign j_inc = r_j + CNT_W'(1);
    assign j_dec = r_j - CNT_W'(1);

    assign o_stat.cmd        = r_cmd;
    assign o_stat.pos_ok     = LCNT_W'(r_pos) < LCNT_W'(r_count);
    assign o_stat.full       = r_count == CNT_W'(DEPTH);
    assign o_stat.empty      = r_count == '0;
    assign o_stat.shift_done = j_inc >= r_count;
    assign o_stat.disp_last  = j_inc == r_count;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        we    = 1'b0;
        waddr = r_count[ADDR_W-1:0];
        wdata = r_word;
        if (i_ctrl.wr_append) begin
            we = 1'b1;
        end else if (i_ctrl.wr_update) begin
            we    = 1'b1;
            waddr = r_pos[ADDR_W-1:0];
        end else if ((i_ctrl.shift_step || i_ctrl.shift_end) && r_pend) begin
            we    = 1'b1;
            waddr = j_dec[ADDR_W-1:0];
            wdata = rdata;
        end
        raddr = (i_ctrl.shift_step || i_ctrl.emit_entry) ? j_inc[ADDR_W-1:0]
                                                         : r_j[ADDR_W-1:0];
    end

    cls_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_pos  <= i_position;
            r_word <= i_data_word;
        end
        if (i_ctrl.set_status) begin
            r_stat_code <= i_ctrl.status;
        end
        if (i_ctrl.j_from_pos) begin
            r_j <= CNT_W'(r_pos);
        end else if (i_ctrl.j_clear) begin
            r_j <= '0;
        end else if (i_ctrl.shift_step || i_ctrl.emit_entry) begin
            r_j <= j_inc;
        end
        if (i_ctrl.emit_status) begin
            r_out_status <= r_stat_code;
            r_out_value  <= '0;
            r_out_index  <= '0;
            r_out_count  <= LCNT_W'(r_count);
            r_out_last   <= 1'b1;
        end else if (i_ctrl.emit_entry) begin
            r_out_status <= ST_OK;
            r_out_value  <= rdata;
            r_out_index  <= IDX_W'(r_j);
            r_out_count  <= LCNT_W'(r_count);
            r_out_last   <= o_stat.disp_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.wr_append) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_ctrl.shift_end) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_ctrl.shift_step) begin
                r_pend <= 1'b1;
            end else if (i_ctrl.shift_end) begin
                r_pend <= 1'b0;
            end
            if (i_ctrl.emit_status || i_ctrl.emit_entry) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_value = r_out_value;
    assign o_entry_index = r_out_index;
    assign o_live_count  = r_out_count;
    assign o_last        = r_out_last;
endmodule

### sv/compacting_list_store_top.sv
// ----------------------------------------------------------------------------
// compacting_list_store_top
// Dense list of signed 32-bit words with insert, update, delete and display.
// ----------------------------------------------------------------------------
// The block takes one command at a time and holds at most DEPTH entries in a
// single-port-write, registered-read RAM. Insert and update write the RAM and
// then report a status result. Delete closes the gap behind the deleted entry
// by moving one entry per cycle through the RAM, then reports its status.
// Display reads its first entry ahead, then gives one result per cycle while
// the result channel accepts them, one for each stored entry, set by the RAM
// read port. A rejected command and a display of an empty list give a single
// status result. A waiting result does not block the next command transfer,
// and back pressure on the result channel simply stretches the work.
module compacting_list_store_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cls_in_if.sink    i_cmd_ch,
    cls_out_if.source o_res_ch
);
    import cls_pkg::*;

    t_dp_ctrl ctrl;
    t_dp_stat stat;

    cls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd_ch.valid),
        .o_in_ready (i_cmd_ch.ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    cls_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd_ch.cmd),
        .i_position    (i_cmd_ch.position),
        .i_data_word   (i_cmd_ch.data_word),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .o_out_valid   (o_res_ch.valid),
        .i_out_ready   (o_res_ch.ready),
        .o_status      (o_res_ch.status),
        .o_entry_value (o_res_ch.entry_value),
        .o_entry_index (o_res_ch.entry_index),
        .o_live_count  (o_res_ch.live_count),
        .o_last        (o_res_ch.last)
    );
endmodule

### sv/cls_checker.sv
// ----------------------------------------------------------------------------
// cls_checker
// Port-level checks of the compacting list store, bound to the top level.
// ----------------------------------------------------------------------------
module cls_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [1:0]                        i_status,
    input logic signed [cls_pkg::WORD_W-1:0] i_entry_value,
    input logic [cls_pkg::IDX_W-1:0]         i_entry_index,
    input logic [cls_pkg::LCNT_W-1:0]        i_live_count,
    input logic                              i_last
);
    import cls_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_entry_value) && $stable(i_live_count) && $stable(i_last))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command transfer taken while busy");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_live_count == LCNT_W'(DEPTH))
        else $error("full status with room left");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_EMPTY |->
            i_live_count == '0 && i_last && i_entry_value == '0)
        else $error("malformed empty result");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> LCNT_W'(i_entry_index) < i_live_count
            || i_entry_index == '0)
        else $error("entry index beyond live count");
endmodule

bind compacting_list_store_top cls_checker u_cls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_cmd_ch.valid),
    .i_in_ready    (i_cmd_ch.ready),
    .i_out_valid   (o_res_ch.valid),
    .i_out_ready   (o_res_ch.ready),
    .i_status      (o_res_ch.status),
    .i_entry_value (o_res_ch.entry_value),
    .i_entry_index (o_res_ch.entry_index),
    .i_live_count  (o_res_ch.live_count),
    .i_last        (o_res_ch.last)
);
